### rtl/core/stepped_easing_interpolator_core_assert.svh
// Assertion helpers for the core RTL.
`ifndef STEPPED_EASING_INTERPOLATOR_CORE_ASSERT_SVH
`define STEPPED_EASING_INTERPOLATOR_CORE_ASSERT_SVH

// Clock and reset qualifier for every check.
`define SEI_CLK_RST @(posedge i_clk) disable iff (!i_rst_n)

// Concurrent check with the standard qualifier.
`define SEI_ASSERT(label, prop, msg) \
    label: assert property (`SEI_CLK_RST prop) else $error(msg);

`endif

### rtl/core/sei_pkg.sv
package sei_pkg;

    localparam int DATA_W      = 32;
    localparam int FRAC_BITS   = 16;
    localparam int SINE_DEPTH  = 256;
    localparam int SINE_ADDR_W = $clog2(SINE_DEPTH);
    localparam int FX_W        = FRAC_BITS + 1;
    localparam int MAG_W       = DATA_W + 1;
    localparam int DIFF_W      = DATA_W + 1;
    localparam int PROD_W      = MAG_W + FX_W;
    localparam int RES_W       = PROD_W - (FRAC_BITS - 2);
    localparam int VAL_W       = RES_W + 2;
    localparam int MUL_CNT_W   = $clog2(FX_W);
    localparam int DIV_CNT_W   = $clog2(FRAC_BITS);
    localparam int CURVE_W     = 2;
    localparam int CFG_IDX_W   = 3;

    localparam logic [FX_W-1:0]   ONE_FX     = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [DATA_W-1:0] STEP_RESET = DATA_W'(655);
    localparam logic [63:0]       HALF_PI_Q62 = 64'h6487ED5110B4611A;

    localparam logic [CFG_IDX_W-1:0] CFG_START_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_X   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 3'd4;

    localparam logic [CURVE_W-1:0] CURVE_LINEAR = 2'd0;
    localparam logic [CURVE_W-1:0] CURVE_SINE   = 2'd1;
    localparam logic [CURVE_W-1:0] CURVE_CUBIC  = 2'd2;
    localparam logic [CURVE_W-1:0] CURVE_NONE   = 2'd3;

    localparam logic OP_RESTART = 1'b1;

    typedef enum logic [1:0] {
        RND_FX   = 2'd0,
        RND_HALF = 2'd1,
        RND_CUBE = 2'd2
    } t_rnd;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } t_phase;

    typedef logic [FX_W-1:0] t_sine_tab [0:SINE_DEPTH];

    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // Quarter-wave sine in Q62 by Taylor series, rounded to the fraction width.
    function automatic t_sine_tab build_sine_tab();
        t_sine_tab   tab;
        logic [63:0] qd;
        logic [63:0] rd;
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] term;
        logic [63:0] sum;
        logic        stop;
        qd = HALF_PI_Q62 / SINE_DEPTH;
        rd = HALF_PI_Q62 % SINE_DEPTH;
        for (int k = 0; k <= SINE_DEPTH; k++) begin
            a    = qd * 64'(k) + (rd * 64'(k)) / SINE_DEPTH;
            a2   = mul_q62(a, a);
            term = a;
            sum  = a;
            stop = 1'b0;
            for (int n = 1; n < 24; n++) begin
                if (!stop) begin
                    term = mul_q62(term, a2) / 64'((2 * n) * (2 * n + 1));
                    if (term == 64'd0) begin
                        stop = 1'b1;
                    end else if (n[0]) begin
                        sum = sum - term;
                    end else begin
                        sum = sum + term;
                    end
                end
            end
            tab[k] = FX_W'((sum + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS));
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine_tab();

endpackage

### rtl/core/sei_in_if.sv
interface sei_in_if;
    import sei_pkg::*;

    logic               valid;
    logic               ready;
    logic               op;
    logic               advance;
    logic [CURVE_W-1:0] curve;

    modport source (output valid, op, advance, curve, input ready);
    modport sink (input valid, op, advance, curve, output ready);
endinterface

### rtl/core/sei_out_if.sv
interface sei_out_if;
    import sei_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] position;
    logic              out_of_range;

    modport source (output valid, value, position, out_of_range, input ready);
    modport sink (input valid, value, position, out_of_range, output ready);
endinterface

### rtl/core/sei_div.sv
module sei_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [sei_pkg::MAG_W-1:0]     i_num,
    input  logic [sei_pkg::MAG_W-1:0]     i_den,
    output logic                          o_done,
    output logic [sei_pkg::FRAC_BITS-1:0] o_quot
);
    import sei_pkg::*;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(FRAC_BITS - 1);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [MAG_W-1:0]     r_rem;
    logic [MAG_W-1:0]     r_den;
    logic [FRAC_BITS-1:0] r_quot;
    logic [MAG_W:0]       w_rem2;
    logic                 w_ge;

    // Restoring division, one quotient bit per cycle; numerator starts below divisor.
    assign w_rem2 = {r_rem, 1'b0};
    assign w_ge   = w_rem2 >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem  <= w_ge ? MAG_W'(w_rem2 - {1'b0, r_den}) : w_rem2[MAG_W-1:0];
            r_quot <= {r_quot[FRAC_BITS-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

### rtl/core/sei_mul.sv
module sei_mul (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [sei_pkg::MAG_W-1:0]  i_a,
    input  logic [sei_pkg::FX_W-1:0]   i_m,
    output logic                       o_done,
    output logic [sei_pkg::PROD_W-1:0] o_prod
);
    import sei_pkg::*;

    localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(FX_W - 1);

    logic                 r_busy;
    logic                 r_done;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic [PROD_W-1:0]    r_acc;
    logic [MAG_W-1:0]     r_a;
    logic [FX_W-1:0]      r_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MUL_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift-add, multiplier bits taken most significant first.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_m   <= i_m;
        end else if (r_busy) begin
            r_acc <= {r_acc[PROD_W-2:0], 1'b0} + (r_m[FX_W-1] ? PROD_W'(r_a) : '0);
            r_m   <= {r_m[FX_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

### rtl/core/stepped_easing_interpolator_core.sv
// Channel  Dir  Payload                             Transaction when
// i_in     in   op, advance, curve                  valid && ready
// o_out    out  value, position, out_of_range       valid && ready
// i_cfg    in   i_cfg_idx, i_cfg_data               i_cfg_we
//
// One item at a time; ready is high only when the sequencer is idle.
// Linear takes one serial product, sinusoidal two and smooth cubic three, after a divide;
// t of 0 or 1 needs no divide, and a sine at the table end needs one product only.
// The work is done by the 16-step serial divider and the 17-step serial product.
// A finished result waits in the output register while the next item is taken.
// Reset is synchronous; it loads the default endpoints and step and clears the position.
`include "stepped_easing_interpolator_core_assert.svh"

module stepped_easing_interpolator_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sei_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sei_pkg::DATA_W-1:0]    i_cfg_data,
    sei_in_if.sink                        i_in,
    sei_out_if.source                     o_out
);
    import sei_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SETUP = 7'b0000010,
        S_DIV   = 7'b0000100,
        S_EVAL  = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_POST  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state               r_state;
    logic [DATA_W-1:0]    r_sx, r_ex, r_sy, r_ey, r_step, r_pos;
    logic [DATA_W-1:0]    r_res_pos, r_out_value, r_base, r_out_pos;
    logic                 r_oor, r_out_valid, r_out_oor;
    logic [DIFF_W-1:0]    r_num, r_den, r_dy;
    logic [CURVE_W-1:0]   r_curve;
    logic [MAG_W-1:0]     r_dy_mag, r_ma;
    logic                 r_dy_neg, r_past_s, r_past_e, r_neg;
    logic [FX_W-1:0]      r_t, r_u, r_lo, r_mm;
    logic [RES_W-1:0]     r_mag;
    t_rnd                 r_rnd;
    t_phase               r_phase;
    logic                 r_div_start, r_mul_start;

    logic                 w_in_acc;
    logic [DATA_W-1:0]    w_p, w_np;
    logic                 w_oor;
    logic [MAG_W-1:0]     w_an, w_ad, w_dy_mag;
    logic                 w_t_zero, w_t_one, w_past_s, w_past_e;
    logic [DIFF_W:0]      w_d2, w_den2;
    logic [FX_W-1:0]      w_tc, w_tmin, w_q, w_frac, w_u, w_lo, w_hi;
    logic [FX_W+SINE_ADDR_W-1:0] w_qpos;
    logic [SINE_ADDR_W:0] w_idx, w_idx_hi;
    logic                 w_idx_end;
    logic                 w_div_done, w_mul_done;
    logic [FRAC_BITS-1:0] w_quot;
    logic [PROD_W-1:0]    w_prod, w_rsum;
    logic [RES_W-1:0]     w_rnd;
    logic [VAL_W-1:0]     w_sum;
    logic [DATA_W-1:0]    w_value;

    sei_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (w_an),
        .i_den   (w_ad),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    sei_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_a     (r_ma),
        .i_m     (r_mm),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    assign w_in_acc = i_in.valid && i_in.ready;
    assign w_p      = (i_in.op == OP_RESTART) ? r_sx : r_pos;
    assign w_np     = w_p + (i_in.advance ? r_step : '0);
    assign w_oor    = ($signed(w_np) > $signed(r_ex)) || ($signed(w_np) < $signed(r_sx));

    // Ratio setup
    assign w_an     = r_num[DIFF_W-1] ? MAG_W'(-r_num) : MAG_W'(r_num);
    assign w_ad     = r_den[DIFF_W-1] ? MAG_W'(-r_den) : MAG_W'(r_den);
    assign w_dy_mag = r_dy[DIFF_W-1] ? MAG_W'(-r_dy) : MAG_W'(r_dy);
    assign w_t_zero = (r_num == '0) || (r_num[DIFF_W-1] != r_den[DIFF_W-1]);
    assign w_t_one  = w_an >= w_ad;
    assign w_d2     = {r_num, 1'b0};
    assign w_den2   = {r_den[DIFF_W-1], r_den};
    assign w_past_s = r_den[DIFF_W-1] ? ($signed(w_d2) < $signed(w_den2))
                                      : ($signed(w_d2) > $signed(w_den2));
    assign w_past_e = r_den[DIFF_W-1] ? ($signed(w_d2) <= $signed(w_den2))
                                      : ($signed(w_d2) >= $signed(w_den2));

    // Sine table addressing: fold t about the midpoint, then split into index and fraction
    assign w_tc      = ONE_FX - r_t;
    assign w_tmin    = (r_t < w_tc) ? r_t : w_tc;
    assign w_q       = {w_tmin[FX_W-2:0], 1'b0};
    assign w_qpos    = {{SINE_ADDR_W{1'b0}}, w_q} << SINE_ADDR_W;
    assign w_idx     = w_qpos[FX_W+SINE_ADDR_W-1:FRAC_BITS];
    assign w_frac    = FX_W'(w_qpos[FRAC_BITS-1:0]);
    assign w_idx_end = w_idx >= (SINE_ADDR_W+1)'(SINE_DEPTH);
    assign w_idx_hi  = w_idx_end ? w_idx : w_idx + 1'b1;
    assign w_lo      = SINE_TAB[w_idx];
    assign w_hi      = SINE_TAB[w_idx_hi];
    assign w_u       = r_past_e ? w_tc : r_t;

    // Round to nearest; magnitudes only, so ties go away from zero
    always_comb begin
        case (r_rnd)
            RND_HALF: begin
                w_rsum = w_prod + (PROD_W'(1) << FRAC_BITS);
                w_rnd  = RES_W'(w_rsum >> (FRAC_BITS + 1));
            end
            RND_CUBE: begin
                w_rsum = w_prod + (PROD_W'(1) << (FRAC_BITS - 3));
                w_rnd  = RES_W'(w_rsum >> (FRAC_BITS - 2));
            end
            default: begin
                w_rsum = w_prod + (PROD_W'(1) << (FRAC_BITS - 1));
                w_rnd  = RES_W'(w_rsum >> FRAC_BITS);
            end
        endcase
    end

    // Final add and saturate
    assign w_sum = r_neg ? VAL_W'($signed(r_base)) - VAL_W'(r_mag)
                         : VAL_W'($signed(r_base)) + VAL_W'(r_mag);
    always_comb begin
        if (&w_sum[VAL_W-1:DATA_W-1] || ~|w_sum[VAL_W-1:DATA_W-1]) begin
            w_value = w_sum[DATA_W-1:0];
        end else begin
            w_value = {w_sum[VAL_W-1], {(DATA_W-1){~w_sum[VAL_W-1]}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx   <= '0;
            r_ex   <= DATA_W'(ONE_FX);
            r_sy   <= '0;
            r_ey   <= DATA_W'(ONE_FX);
            r_step <= STEP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_X: r_sx   <= i_cfg_data;
                CFG_END_X:   r_ex   <= i_cfg_data;
                CFG_START_Y: r_sy   <= i_cfg_data;
                CFG_END_Y:   r_ey   <= i_cfg_data;
                CFG_STEP:    r_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_div_start <= 1'b0;
            r_mul_start <= 1'b0;
            r_pos       <= '0;
            r_phase     <= PH_FIRST;
        end else begin
            r_div_start <= 1'b0;
            r_mul_start <= 1'b0;
            if (o_out.valid && o_out.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_pos     <= w_np;
                        r_res_pos <= w_np;
                        r_oor     <= w_oor;
                        r_num     <= {w_p[DATA_W-1], w_p} - {r_sx[DATA_W-1], r_sx};
                        r_den     <= {r_ex[DATA_W-1], r_ex} - {r_sx[DATA_W-1], r_sx};
                        r_dy      <= {r_ey[DATA_W-1], r_ey} - {r_sy[DATA_W-1], r_sy};
                        r_curve   <= i_in.curve;
                        r_state   <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_dy_mag <= w_dy_mag;
                    r_dy_neg <= r_dy[DIFF_W-1];
                    r_past_s <= w_past_s;
                    r_past_e <= w_past_e;
                    r_neg    <= 1'b0;
                    r_mag    <= '0;
                    if (r_curve == CURVE_NONE) begin
                        r_base  <= '0;
                        r_state <= S_DONE;
                    end else if (r_den == '0) begin
                        r_base  <= r_sy;
                        r_state <= S_DONE;
                    end else if (w_t_zero) begin
                        r_t     <= '0;
                        r_state <= S_EVAL;
                    end else if (w_t_one) begin
                        r_t     <= ONE_FX;
                        r_state <= S_EVAL;
                    end else begin
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_t     <= {1'b0, w_quot};
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_mul_start <= 1'b1;
                    r_state     <= S_MUL;
                    r_phase     <= PH_FIRST;
                    r_rnd       <= RND_FX;
                    case (r_curve)
                        CURVE_SINE: begin
                            if (w_idx_end) begin
                                r_ma    <= r_dy_mag;
                                r_mm    <= w_lo;
                                r_rnd   <= RND_HALF;
                                r_phase <= PH_SECOND;
                            end else begin
                                r_lo <= w_lo;
                                r_ma <= MAG_W'(w_hi - w_lo);
                                r_mm <= w_frac;
                            end
                        end
                        CURVE_CUBIC: begin
                            r_u  <= w_u;
                            r_ma <= MAG_W'(w_u);
                            r_mm <= w_u;
                        end
                        default: begin
                            r_ma <= r_dy_mag;
                            r_mm <= r_t;
                        end
                    endcase
                end
                S_MUL: begin
                    if (w_mul_done) begin
                        r_state <= S_POST;
                    end
                end
                S_POST: begin
                    r_mag   <= w_rnd;
                    r_state <= S_DONE;
                    case (r_curve)
                        CURVE_SINE: begin
                            if (r_phase == PH_FIRST) begin
                                r_ma        <= r_dy_mag;
                                r_mm        <= FX_W'(r_lo + FX_W'(w_rnd));
                                r_rnd       <= RND_HALF;
                                r_phase     <= PH_SECOND;
                                r_mul_start <= 1'b1;
                                r_state     <= S_MUL;
                            end else begin
                                r_base <= r_past_s ? r_ey : r_sy;
                                r_neg  <= r_dy_neg ^ r_past_s;
                            end
                        end
                        CURVE_CUBIC: begin
                            case (r_phase)
                                PH_FIRST: begin
                                    r_ma        <= MAG_W'(w_rnd);
                                    r_mm        <= r_u;
                                    r_phase     <= PH_SECOND;
                                    r_mul_start <= 1'b1;
                                    r_state     <= S_MUL;
                                end
                                PH_SECOND: begin
                                    r_ma        <= r_dy_mag;
                                    r_mm        <= FX_W'(w_rnd);
                                    r_rnd       <= RND_CUBE;
                                    r_phase     <= PH_THIRD;
                                    r_mul_start <= 1'b1;
                                    r_state     <= S_MUL;
                                end
                                default: begin
                                    r_base <= r_past_e ? r_ey : r_sy;
                                    r_neg  <= r_dy_neg ^ r_past_e;
                                end
                            endcase
                        end
                        default: begin
                            r_base <= r_sy;
                            r_neg  <= r_dy_neg;
                        end
                    endcase
                end
                S_DONE: begin
                    // Hold until the output register is free
                    if (!r_out_valid || o_out.ready) begin
                        r_out_value <= w_value;
                        r_out_pos   <= r_res_pos;
                        r_out_oor   <= r_oor;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.value        = r_out_value;
    assign o_out.position     = r_out_pos;
    assign o_out.out_of_range = r_out_oor;

    `SEI_ASSERT(a_accept_to_setup, w_in_acc |=> (r_state == S_SETUP), "accepted transaction did not start setup")
    `SEI_ASSERT(a_result_from_done, $rose(o_out.valid) |-> $past(r_state == S_DONE), "result appeared outside completion")
    `SEI_ASSERT(a_mul_done_in_mul, w_mul_done |-> (r_state == S_MUL), "multiplier finished outside multiply wait")
    `SEI_ASSERT(a_div_done_in_div, w_div_done |-> (r_state == S_DIV), "divider finished outside divide wait")
endmodule

### bench/tb.sv
`timescale 1ns / 100ps

module tb;
    import sei_pkg::*;

    typedef struct {
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] position;
        logic              oor;
    } ease_result_t;

    typedef struct {
        logic               op;
        logic               adv;
        logic [CURVE_W-1:0] crv;
        bit                 typed;
        logic [DATA_W-1:0]  value;
        logic [DATA_W-1:0]  position;
        logic               oor;
    } ease_row_t;

    logic i_clk;
    logic i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [DATA_W-1:0]    i_cfg_data;

    sei_in_if  in_ch();
    sei_out_if out_ch();

    stepped_easing_interpolator_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // predictor state
    longint unsigned   quarter_sine [0:SINE_DEPTH];
    logic [DATA_W-1:0] m_x1, m_x2, m_y1, m_y2, m_step, m_pos;

    ease_result_t awaited_q[$];
    int  mismatches;
    int  results_seen;
    int  items_sent;
    int  cfg_phases;
    bit  calm;
    int  hold_requests;
    int  holds_done;
    int  hold_left;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic longint unsigned q62_mul(longint unsigned a, longint unsigned b);
        logic [127:0] pr;
        pr = {64'd0, a} * {64'd0, b};
        return pr[125:62];
    endfunction

    function automatic void fill_quarter_sine();
        longint unsigned step_q, rem_q, ang, ang2, term, acc;
        step_q = HALF_PI_Q62 / SINE_DEPTH;
        rem_q  = HALF_PI_Q62 % SINE_DEPTH;
        for (int k = 0; k <= SINE_DEPTH; k++) begin
            ang  = step_q * k + (rem_q * k) / SINE_DEPTH;
            ang2 = q62_mul(ang, ang);
            term = ang;
            acc  = ang;
            for (int n = 1; n < 24; n++) begin
                term = q62_mul(term, ang2) / ((2 * n) * (2 * n + 1));
                if (term == 0) break;
                if (n % 2 == 1) acc = acc - term;
                else acc = acc + term;
            end
            quarter_sine[k] = (acc + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);
        end
    endfunction

    // a*m / 2^sh rounded to nearest, ties away from zero
    function automatic longint mul_round(longint a, longint m, int sh);
        longint mag, r;
        mag = (a < 0) ? -a : a;
        r = (mag * m + (64'sd1 <<< (sh - 1))) >>> sh;
        return (a < 0) ? -r : r;
    endfunction

    function automatic logic [DATA_W-1:0] clamp32(longint v);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[DATA_W-1:0];
    endfunction

    function automatic longint sine_lookup(longint q);
        longint pos, idx, frac, lo, hi;
        pos  = q * SINE_DEPTH;
        idx  = pos >>> FRAC_BITS;
        frac = pos & ((64'sd1 <<< FRAC_BITS) - 1);
        if (idx >= SINE_DEPTH) return longint'(quarter_sine[SINE_DEPTH]);
        lo = longint'(quarter_sine[idx]);
        hi = longint'(quarter_sine[idx + 1]);
        return lo + mul_round(hi - lo, frac, FRAC_BITS);
    endfunction

    function automatic logic [DATA_W-1:0] ease_value(logic [DATA_W-1:0] p,
                                                     logic [CURVE_W-1:0] crv);
        longint one, x1, x2, y1, y2, den, dy, num, d2, t, an, ad, q, h, u, u2, u3, w;
        bit past_strict, past_eq;
        one = 64'sd1 <<< FRAC_BITS;
        x1  = longint'($signed(m_x1));
        x2  = longint'($signed(m_x2));
        y1  = longint'($signed(m_y1));
        y2  = longint'($signed(m_y2));
        den = x2 - x1;
        dy  = y2 - y1;
        num = longint'($signed(p)) - x1;
        d2  = 2 * num;
        if (crv == CURVE_NONE) return '0;
        if (den == 0) return m_y1;
        if (num == 0 || ((num < 0) != (den < 0))) begin
            t = 0;
        end else begin
            an = (num < 0) ? -num : num;
            ad = (den < 0) ? -den : den;
            t = (an >= ad) ? one : (an <<< FRAC_BITS) / ad;
        end
        past_strict = (den > 0) ? (d2 > den) : (d2 < den);
        past_eq     = (den > 0) ? (d2 >= den) : (d2 <= den);
        if (crv == CURVE_LINEAR) return clamp32(y1 + mul_round(dy, t, FRAC_BITS));
        if (crv == CURVE_SINE) begin
            q = 2 * ((t < one - t) ? t : one - t);
            h = mul_round(dy, sine_lookup(q), FRAC_BITS + 1);
            return clamp32(past_strict ? y2 - h : y1 + h);
        end
        u  = past_eq ? one - t : t;
        u2 = (u * u + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        u3 = (u2 * u + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        w  = mul_round(dy, u3, FRAC_BITS - 2);
        return clamp32(past_eq ? y2 - w : y1 + w);
    endfunction

    // advance the model by one transaction
    function automatic ease_result_t ease_step(logic op, logic adv, logic [CURVE_W-1:0] crv);
        ease_result_t r;
        if (op == OP_RESTART) m_pos = m_x1;
        r.value = ease_value(m_pos, crv);
        if (adv) m_pos = m_pos + m_step;
        r.position = m_pos;
        r.oor = ($signed(m_pos) > $signed(m_x2)) || ($signed(m_pos) < $signed(m_x1));
        return r;
    endfunction

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_START_X: m_x1   = data;
            CFG_END_X:   m_x2   = data;
            CFG_START_Y: m_y1   = data;
            CFG_END_Y:   m_y2   = data;
            CFG_STEP:    m_step = data;
            default: ;
        endcase
    endtask

    // drop the input, wait for the block to drain, then load a full register set
    task automatic reconfigure(logic [DATA_W-1:0] x1, logic [DATA_W-1:0] x2,
                               logic [DATA_W-1:0] y1, logic [DATA_W-1:0] y2,
                               logic [DATA_W-1:0] stp);
        in_ch.valid <= 1'b0;
        while (awaited_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        cfg_write(CFG_START_X, x1);
        cfg_write(CFG_END_X, x2);
        cfg_write(CFG_START_Y, y1);
        cfg_write(CFG_END_Y, y2);
        cfg_write(CFG_STEP, stp);
        cfg_write(CFG_IDX_W'($urandom_range(5, 7)), $urandom());
        i_cfg_we <= 1'b0;
        cfg_phases++;
    endtask

    task automatic send_item(logic op, logic adv, logic [CURVE_W-1:0] crv, bit typed,
                             ease_result_t typed_res);
        ease_result_t r;
        while (!calm && $urandom_range(99) < 27) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.op      <= op;
        in_ch.advance <= adv;
        in_ch.curve   <= crv;
        do @(posedge i_clk); while (!in_ch.ready);
        r = ease_step(op, adv, crv);
        awaited_q.push_back(typed ? typed_res : r);
        items_sent++;
    endtask

    task automatic send_random(bit well_formed);
        int n;
        ease_result_t none;
        none = '{default: '0};
        if (well_formed) begin
            n = $urandom_range(8, 40);
            send_item(OP_RESTART, 1'b1, CURVE_W'($urandom_range(0, 2)), 0, none);
            for (int i = 0; i < n; i++)
                send_item(1'b0, ($urandom_range(9) != 0), CURVE_W'($urandom_range(0, 2)),
                          0, none);
        end else begin
            send_item($urandom_range(1), $urandom_range(1), CURVE_W'($urandom_range(0, 3)),
                      0, none);
        end
    endtask

    // receiving side: check, then choose ready for the next cycle
    always @(posedge i_clk) begin
        ease_result_t e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_seen++;
            if (awaited_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: value=%h position=%h oor=%b",
                             out_ch.value, out_ch.position, out_ch.out_of_range);
            end else begin
                e = awaited_q.pop_front();
                if (out_ch.value !== e.value || out_ch.position !== e.position ||
                    out_ch.out_of_range !== e.oor) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch #%0d: value %h/%h position %h/%h oor %b/%b",
                                 results_seen, e.value, out_ch.value, e.position,
                                 out_ch.position, e.oor, out_ch.out_of_range);
                end
            end
        end
        if (hold_left == 0 && hold_requests != holds_done) begin
            holds_done++;
            hold_left = 500;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= calm || ($urandom_range(99) >= 27);
        end
    end

    ease_row_t rows[$];

    initial begin
        int lead;
        int span;
        ease_result_t typed_res;
        logic [DATA_W-1:0] x1, dx;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= '0;
        i_cfg_data   <= '0;
        in_ch.valid  <= 1'b0;
        in_ch.op     <= 1'b0;
        in_ch.advance <= 1'b0;
        in_ch.curve  <= CURVE_LINEAR;
        mismatches = 0; results_seen = 0; items_sent = 0; cfg_phases = 0;
        calm = 0; hold_requests = 0; holds_done = 0; hold_left = 0;
        fill_quarter_sine();
        m_x1 = '0; m_x2 = 32'h0001_0000; m_y1 = '0; m_y2 = 32'h0001_0000;
        m_step = STEP_RESET; m_pos = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset: position at the curve start, every curve gives start_y
        rows.push_back('{1'b0, 1'b0, CURVE_LINEAR, 1, 32'h0, 32'h0, 1'b0});
        rows.push_back('{1'b0, 1'b0, CURVE_SINE,   1, 32'h0, 32'h0, 1'b0});
        rows.push_back('{1'b0, 1'b0, CURVE_CUBIC,  1, 32'h0, 32'h0, 1'b0});
        rows.push_back('{1'b0, 1'b1, CURVE_NONE,   1, 32'h0, 32'd655, 1'b0});
        rows.push_back('{1'b0, 1'b1, CURVE_LINEAR, 0, 0, 0, 0});
        rows.push_back('{1'b0, 1'b1, CURVE_SINE,   0, 0, 0, 0});
        rows.push_back('{1'b0, 1'b1, CURVE_CUBIC,  0, 0, 0, 0});
        rows.push_back('{OP_RESTART, 1'b0, CURVE_LINEAR, 1, 32'h0, 32'h0, 1'b0});
        rows.push_back('{OP_RESTART, 1'b1, CURVE_CUBIC, 1, 32'h0, 32'd655, 1'b0});
        rows.push_back('{1'b0, 1'b0, CURVE_NONE, 1, 32'h0, 32'd655, 1'b0});
        foreach (rows[i]) begin
            typed_res = '{rows[i].value, rows[i].position, rows[i].oor};
            send_item(rows[i].op, rows[i].adv, rows[i].crv, rows[i].typed, typed_res);
        end

        // midpoint, end point and overshoot on the unit curve
        reconfigure(32'h0, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0000_4000);
        for (int i = 0; i < 6; i++)
            send_random(0);
        for (int c = 0; c < 3; c++) begin
            send_item(OP_RESTART, 1'b1, CURVE_W'(c), 0, typed_res);
            for (int i = 0; i < 6; i++)
                send_item(1'b0, 1'b1, CURVE_W'(c), 0, typed_res);
        end
        // reversed endpoints
        reconfigure(32'h0001_0000, 32'h0, 32'h0002_0000, 32'hFFFF_0000, 32'hFFFF_C000);
        send_random(1);
        // equal endpoints
        reconfigure(32'h0003_0000, 32'h0003_0000, 32'h1234_5678, 32'h0, 32'h0000_8000);
        send_random(1);
        // extremes: full range endpoints, saturating values, wrap of position
        reconfigure(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1000_0000);
        send_random(1);
        reconfigure(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        send_random(1);
        reconfigure(32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
        send_random(1);

        // random part: random curves, mostly well-formed sweeps
        while (items_sent < 1180) begin
            if ($urandom_range(5) == 0 || items_sent % 150 < 40) begin
                if ($urandom_range(3) == 0) begin
                    reconfigure($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
                end else begin
                    x1   = $urandom();
                    dx   = 32'd1 << $urandom_range(2, 26);
                    if ($urandom_range(3) == 0) dx = -dx;
                    span = $urandom_range(4, 64);
                    reconfigure(x1, x1 + dx, $urandom(), $urandom_range(1) ? $urandom() :
                                $urandom_range(0, 32'h0004_0000),
                                $signed(dx) / span);
                end
            end
            lead = items_sent;
            calm = (lead > 450 && lead < 650);
            if (lead > 700 && hold_requests == 0) hold_requests = 1;
            send_random($urandom_range(99) < 80);
        end
        in_ch.valid <= 1'b0;
        calm = 0;

        span = 0;
        while (awaited_q.size() != 0 && span < 20000) begin
            @(posedge i_clk);
            span++;
        end
        repeat (200) @(posedge i_clk);
        $display("covered %0d transactions in %0d register settings, %0d results checked",
                 items_sent, cfg_phases, results_seen);
        if (mismatches == 0 && awaited_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, awaited_q.size());
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
